// ===== rtl/core/dtfp_pkg.sv =====
// shared constants and tables for the decimal text to fixed point parser
package dtfp_pkg;

  localparam int unsigned CODE_W  = 21;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FRAC_W  = 4;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [CODE_W-1:0] CH_END   = 21'h00;
  localparam logic [CODE_W-1:0] CH_MINUS = 21'h2D;
  localparam logic [CODE_W-1:0] CH_PLUS  = 21'h2B;
  localparam logic [CODE_W-1:0] CH_POINT = 21'h2E;
  localparam logic [CODE_W-1:0] CH_ZERO  = 21'h30;
  localparam logic [CODE_W-1:0] CH_NINE  = 21'h39;

  // register index, taken from paddr above the byte offset
  localparam logic REG_FRAC_DIGITS = 1'b0;

  localparam logic [63:0] MAG_LIMIT = 64'h0000_0000_7FFF_FFFF;

  // powers of ten for padding missing fractional digits
  localparam logic [63:0] POW10 [16] = '{
    64'd1,
    64'd10,
    64'd100,
    64'd1000,
    64'd10000,
    64'd100000,
    64'd1000000,
    64'd10000000,
    64'd100000000,
    64'd1000000000,
    64'd10000000000,
    64'd100000000000,
    64'd1000000000000,
    64'd10000000000000,
    64'd100000000000000,
    64'd1000000000000000
  };

endpackage

// ===== rtl/core/dtfp_char_if.sv =====
// character and result channel interfaces
interface dtfp_char_if import dtfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface dtfp_result_if import dtfp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink (input valid, input value, input overflow, output ready);
endinterface

// ===== rtl/core/decimal_text_to_fixed_point.sv =====
// decimal text to fixed point parser: one character per beat, one result per string
// throughput: one character beat per cycle unless every stage is full and results stall
// result path: a result passes end capture, partial products of the padding multiply
//   and the final sum, then leaves the output register
// reset: rst is synchronous and active high; it clears the parser, frac_digits and all
//   stage valids; payload registers are not reset
module decimal_text_to_fixed_point import dtfp_pkg::*; #(
  parameter int unsigned ACC_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  dtfp_char_if.sink           chars,
  dtfp_result_if.source       results,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // accumulator step is computed wide enough for acc*10+9; overflow compare is
  // done on at most 64 bits of it
  localparam int unsigned NW = ACC_WIDTH + 4;
  localparam int unsigned CW = (NW > 64) ? 64 : NW;
  // magnitude limit is the smaller of 2^31-1 and the accumulator range
  localparam logic [63:0] ACC_MASK = (ACC_WIDTH >= 64) ? ~64'd0 :
                                     ((64'd1 << ACC_WIDTH) - 64'd1);
  localparam logic [63:0] LIMIT = (ACC_MASK < MAG_LIMIT) ? ACC_MASK : MAG_LIMIT;

  // largest accumulator that survives padding by k zeros without overflow
  localparam logic [63:0] THRESH [16] = '{
    LIMIT / 64'd1,
    LIMIT / 64'd10,
    LIMIT / 64'd100,
    LIMIT / 64'd1000,
    LIMIT / 64'd10000,
    LIMIT / 64'd100000,
    LIMIT / 64'd1000000,
    LIMIT / 64'd10000000,
    LIMIT / 64'd100000000,
    LIMIT / 64'd1000000000,
    LIMIT / 64'd10000000000,
    LIMIT / 64'd100000000000,
    LIMIT / 64'd1000000000000,
    LIMIT / 64'd10000000000000,
    LIMIT / 64'd100000000000000,
    LIMIT / 64'd1000000000000000
  };

  // ------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------
  logic [FRAC_W-1:0] frac_digits;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_FRAC_DIGITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_digits <= '0;
    end else if (cfg_write) begin
      frac_digits <= pwdata[FRAC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAC_DIGITS) begin
      prdata = PDATA_W'(frac_digits);
    end
  end

  // ------------------------------------------------------------------
  // pipeline handshake: each stage moves when the one after it is free
  // ------------------------------------------------------------------
  logic s1_valid;
  logic s2_valid;
  logic out_valid;
  logic out_free;
  logic s2_free;
  logic in_accept;
  logic end_accept;

  assign out_free    = !out_valid || results.ready;
  assign s2_free     = !s2_valid || out_free;
  assign chars.ready = !s1_valid || s2_free;
  assign in_accept   = chars.valid && chars.ready;
  assign end_accept  = in_accept && (chars.char_code == CH_END);

  // ------------------------------------------------------------------
  // parser state, updated on every accepted character beat
  // ------------------------------------------------------------------
  logic [ACC_WIDTH-1:0] acc;
  logic                 point_seen;
  logic [FRAC_W-1:0]    frac_count;
  logic                 stopped;
  logic                 at_first_char;
  logic                 negative;
  logic                 overflowed;

  logic [ACC_WIDTH-1:0] acc_next;
  logic                 point_seen_next;
  logic [FRAC_W-1:0]    frac_count_next;
  logic                 stopped_next;
  logic                 at_first_char_next;
  logic                 negative_next;
  logic                 overflowed_next;

  logic [CODE_W-1:0]    code;
  logic                 is_digit;
  logic                 is_sign;
  logic [NW-1:0]        step;
  logic [63:0]          step64;
  logic [FRAC_W-1:0]    count_inc;

  assign code     = chars.char_code;
  assign is_digit = (code >= CH_ZERO) && (code <= CH_NINE);
  assign is_sign  = (code == CH_MINUS) || (code == CH_PLUS);

  // acc*10 + digit as two shifts and adds
  assign step   = (NW'(acc) << 3) + (NW'(acc) << 1) + NW'(code[3:0]);
  assign step64 = 64'(step[CW-1:0]);

  assign count_inc = (frac_count == {FRAC_W{1'b1}}) ? frac_count : frac_count + 1'b1;

  always_comb begin
    acc_next           = acc;
    point_seen_next    = point_seen;
    frac_count_next    = frac_count;
    stopped_next       = stopped;
    at_first_char_next = 1'b0;
    negative_next      = negative;
    overflowed_next    = overflowed;

    if (code == CH_END) begin
      // end of string: back to the start state
      acc_next           = '0;
      point_seen_next    = 1'b0;
      frac_count_next    = '0;
      stopped_next       = 1'b0;
      at_first_char_next = 1'b1;
      negative_next      = 1'b0;
      overflowed_next    = 1'b0;
    end else if (at_first_char && is_sign) begin
      // leading sign is consumed here and nowhere else
      negative_next = (code == CH_MINUS);
    end else if (!stopped) begin
      if (code == CH_POINT) begin
        if ((frac_digits == '0) || point_seen) begin
          stopped_next = 1'b1;
        end else begin
          point_seen_next = 1'b1;
          frac_count_next = '0;
        end
      end else if (is_digit) begin
        acc_next = step[ACC_WIDTH-1:0];
        if (step64 > LIMIT) begin
          overflowed_next = 1'b1;
        end
        if (point_seen) begin
          frac_count_next = count_inc;
          if (count_inc >= frac_digits) begin
            stopped_next = 1'b1;
          end
        end
      end else begin
        stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      point_seen    <= 1'b0;
      frac_count    <= '0;
      stopped       <= 1'b0;
      at_first_char <= 1'b1;
      negative      <= 1'b0;
      overflowed    <= 1'b0;
    end else if (in_accept) begin
      acc           <= acc_next;
      point_seen    <= point_seen_next;
      frac_count    <= frac_count_next;
      stopped       <= stopped_next;
      at_first_char <= at_first_char_next;
      negative      <= negative_next;
      overflowed    <= overflowed_next;
    end
  end

  // ------------------------------------------------------------------
  // stage 1: capture the finished accumulator and the padding factor
  // the sign is folded into the factor, so the multiply yields the signed result
  // ------------------------------------------------------------------
  logic [FRAC_W-1:0] done_digits;
  logic [FRAC_W-1:0] pad_count;
  logic [63:0]       pad_factor;
  logic              pad_overflow;

  logic [ACC_WIDTH-1:0] s1_acc;
  logic [63:0]          s1_factor;
  logic                 s1_overflow;

  assign done_digits  = point_seen ? frac_count : '0;
  assign pad_count    = (frac_digits > done_digits) ? (frac_digits - done_digits) : '0;
  assign pad_factor   = negative ? (64'd0 - POW10[pad_count]) : POW10[pad_count];
  // without an earlier overflow the accumulator is within range, so padding
  // overflows exactly when it passes the scaled threshold
  assign pad_overflow = overflowed || (64'(acc) > THRESH[pad_count]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (end_accept) begin
      s1_valid <= 1'b1;
    end else if (s2_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_accept) begin
      s1_acc      <= acc;
      s1_factor   <= pad_factor;
      s1_overflow <= pad_overflow;
    end
  end

  // ------------------------------------------------------------------
  // stage 2: 32x32 partial products of the low 64 bits of acc*factor
  // ------------------------------------------------------------------
  logic [63:0] mul_a;
  logic [63:0] s2_low;
  logic [31:0] s2_mid;
  logic        s2_overflow;

  assign mul_a = 64'(s1_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_valid && s2_free) begin
      s2_valid <= 1'b1;
    end else if (out_free) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_free) begin
      s2_low      <= mul_a[31:0] * s1_factor[31:0];
      s2_mid      <= 32'(mul_a[63:32] * s1_factor[31:0]) +
                     32'(mul_a[31:0] * s1_factor[63:32]);
      s2_overflow <= s1_overflow;
    end
  end

  // ------------------------------------------------------------------
  // stage 3: sum the partial products, wrap to the accumulator, sign-extend or truncate to 32 bits
  // ------------------------------------------------------------------
  logic [63:0]                 prod;
  logic signed [ACC_WIDTH-1:0] prod_acc;
  logic signed [VALUE_W-1:0]   out_value;
  logic                        out_overflow;

  assign prod     = s2_low + {s2_mid, 32'h0};
  assign prod_acc = signed'(prod[ACC_WIDTH-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && out_free) begin
      // sign-extends a narrow accumulator, keeps the low bits of a wide one
      out_value    <= VALUE_W'(prod_acc);
      out_overflow <= s2_overflow;
    end
  end

  assign results.valid    = out_valid;
  assign results.value    = out_value;
  assign results.overflow = out_overflow;

endmodule

// ===== sim/tb_decimal_text_to_fixed_point.sv =====
// self-checking testbench for the decimal text to fixed point parser
`timescale 1ns / 100ps

module tb_decimal_text_to_fixed_point;
  import dtfp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;       // covers the result pipeline plus margin
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASES        = 9;
  localparam int unsigned PHASE_CHARS   = 170;

  // register map: frac_digits at its index, the next index is unmapped
  localparam logic [PADDR_W-1:0] FRAC_ADDR  = {REG_FRAC_DIGITS, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_FRAC_DIGITS, 2'b00};

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;
  } number_t;

  // one directed string: frac setting, text, optional extra code, typed result if obvious
  typedef struct {
    logic [FRAC_W-1:0]         frac;
    string                     text;
    logic [CODE_W-1:0]         tail;
    bit                        typed;
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;
  } string_case_t;

  string_case_t string_cases [9] = '{
    '{4'd0,  "",     21'd0,       1'b1, 32'sd0,            1'b0},  // empty string after reset
    '{4'd0,  "1.5",  21'd0,       1'b1, 32'sd1,            1'b0},  // point not allowed
    '{4'd0,  "4-2",  21'd0,       1'b1, 32'sd4,            1'b0},  // sign after the start
    '{4'd9,  "-2.1", 21'd0,       1'b1, -32'sd2100000000,  1'b0},  // padded near the limit
    '{4'd9,  "3",    21'd0,       1'b0, 32'sd0,            1'b0},  // padding overflows
    '{4'd15, "1",    21'd0,       1'b0, 32'sd0,            1'b0},  // frac above nine
    '{4'd2,  "5..1", 21'd0,       1'b1, 32'sd500,          1'b0},  // second point stops
    '{4'd1,  "+.99", 21'd0,       1'b1, 32'sd9,            1'b0},  // stop after frac digits
    '{4'd1,  "",     21'h1F_FFFF, 1'b1, 32'sd0,            1'b0}   // top code stops at once
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  dtfp_char_if   chars_if ();
  dtfp_result_if results_if ();

  decimal_text_to_fixed_point DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // parser shadow: same state as the block, stepped once per accepted character beat
  logic [FRAC_W-1:0]  shadow_frac;
  logic [VALUE_W-1:0] shadow_acc;
  logic               shadow_point;
  logic [FRAC_W-1:0]  shadow_count;
  logic               shadow_stopped;
  logic               shadow_first;
  logic               shadow_neg;
  logic               shadow_ovf;

  number_t     expected_numbers [$];
  number_t     no_number = '{32'sd0, 1'b0};
  int unsigned mismatches      = 0;
  int unsigned numbers_checked = 0;
  int unsigned sent_chars      = 0;
  int unsigned cycle_count     = 0;
  int unsigned tx_idle_pct     = 15;
  int unsigned rx_idle_pct     = 56;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  function automatic void restart_number();
    shadow_acc     = '0;
    shadow_point   = 1'b0;
    shadow_count   = '0;
    shadow_stopped = 1'b0;
    shadow_first   = 1'b1;
    shadow_neg     = 1'b0;
    shadow_ovf     = 1'b0;
  endfunction

  // acc = acc*10 + d with wrap; sticky flag once the magnitude passes the signed limit
  function automatic void shift_in_digit(input logic [3:0] d);
    logic [63:0] nxt;
    nxt = 64'(shadow_acc) * 64'd10 + 64'(d);
    if (nxt > MAG_LIMIT) shadow_ovf = 1'b1;
    shadow_acc = nxt[VALUE_W-1:0];
  endfunction

  // steps the shadow by one character; returns 1 when a number is complete
  function automatic bit parse_char(input logic [CODE_W-1:0] code, output number_t num);
    int unsigned k;
    num = '{32'sd0, 1'b0};
    if (code == CH_END) begin
      // pad the fractional digits that never came
      if (shadow_frac != 0) begin
        k = shadow_point ? shadow_count : 0;
        while (k < shadow_frac) begin
          shift_in_digit(4'd0);
          k++;
        end
      end
      num.value    = shadow_neg ? VALUE_W'(0 - shadow_acc) : shadow_acc;
      num.overflow = shadow_ovf;
      restart_number();
      return 1'b1;
    end
    if (shadow_first) begin
      shadow_first = 1'b0;
      if (code == CH_MINUS || code == CH_PLUS) begin
        shadow_neg = (code == CH_MINUS);
        return 1'b0;
      end
    end
    if (shadow_stopped) return 1'b0;
    if (code == CH_POINT) begin
      if (shadow_frac == 0 || shadow_point) shadow_stopped = 1'b1;
      else begin
        shadow_point = 1'b1;
        shadow_count = '0;
      end
    end else if (code >= CH_ZERO && code <= CH_NINE) begin
      shift_in_digit(4'(code - CH_ZERO));
      if (shadow_point) begin
        if (shadow_count != 4'hF) shadow_count++;
        if (shadow_count >= shadow_frac) shadow_stopped = 1'b1;
      end
    end else begin
      shadow_stopped = 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [CODE_W-1:0] random_noise();
    case ($urandom_range(4))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_POINT;
      3: return CODE_W'($urandom_range(32, 126));
      default: return CODE_W'($urandom());  // any 21-bit code, end code included
    endcase
  endfunction

  // one character beat: random gap first, then hold valid until the beat is taken
  task automatic send_char(input logic [CODE_W-1:0] code, input bit typed,
                           input number_t typed_num);
    number_t num;
    while ($urandom_range(99) < tx_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= code;
    do @(posedge clk); while (!chars_if.ready);
    sent_chars++;
    if (parse_char(code, num)) begin
      if (typed) num = typed_num;
      expected_numbers.push_back(num);
    end
  endtask

  // sender goes quiet until every pending number is out, then the pipeline drains
  task automatic settle();
    chars_if.valid <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup then access; psel stays up so transfers can run back to back
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[PADDR_W-1:2] == REG_FRAC_DIGITS) shadow_frac = data[FRAC_W-1:0];
  endtask

  task automatic apb_read_check(input logic [PADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(shadow_frac))
      report_mismatch($sformatf("frac_digits read %0h want %0h", prdata, shadow_frac));
  endtask

  task automatic bus_release();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new frac setting: garbage above the field, a write to the unmapped slot, read back
  task automatic set_frac(input logic [FRAC_W-1:0] frac);
    logic [PDATA_W-1:0] data;
    data = ($urandom() & 32'hFFFF_FFF0) | PDATA_W'(frac);
    settle();
    apb_write(FRAC_ADDR, data);
    apb_write(SPARE_ADDR, ~data);
    apb_read_check(FRAC_ADDR);
    bus_release();
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls at random per the current idling pattern
  always @(posedge clk) results_if.ready <= ($urandom_range(99) >= rx_idle_pct);

  // result beats checked in order against the pending numbers
  always @(posedge clk) begin
    number_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_numbers.size() == 0) begin
        report_mismatch($sformatf("result %0d with no number pending", results_if.value));
      end else begin
        want = expected_numbers.pop_front();
        if (results_if.value !== want.value)
          report_mismatch($sformatf("value %0d want %0d", results_if.value, want.value));
        if (results_if.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %0b want %0b (value %0d)",
                                    results_if.overflow, want.overflow, want.value));
        numbers_checked++;
      end
    end
  end

  initial begin
    logic [CODE_W-1:0] codes [$];
    number_t           row_num;
    string             near_limit;
    int unsigned       start_count;
    int unsigned       shape;
    int unsigned       n;
    bit                paused;

    chars_if.valid     = 1'b0;
    chars_if.char_code = '0;
    shadow_frac        = '0;
    restart_number();
    near_limit = "214748364";
    paused     = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // register comes up as zero
    apb_read_check(FRAC_ADDR);
    bus_release();

    // directed table: each row is a whole string, end code included
    foreach (string_cases[i]) begin
      if (string_cases[i].frac != shadow_frac) set_frac(string_cases[i].frac);
      row_num = '{string_cases[i].value, string_cases[i].overflow};
      for (int c = 0; c < string_cases[i].text.len(); c++)
        send_char(CODE_W'(string_cases[i].text[c]), 1'b0, no_number);
      if (string_cases[i].tail != CH_END) send_char(string_cases[i].tail, 1'b0, no_number);
      send_char(CH_END, string_cases[i].typed, row_num);
    end

    // random phases: three per idling pattern, frac settings spread across them
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 3)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (ph)
        0: set_frac(4'd0);
        1: set_frac(4'd9);
        2: set_frac(4'd15);
        3: set_frac(4'd3);
        4: set_frac(4'd1);
        5: set_frac(4'd9);
        6: set_frac(4'd6);
        7: set_frac(FRAC_W'($urandom_range(10, 15)));
        default: set_frac(4'd0);
      endcase
      start_count = sent_chars;
      while (sent_chars - start_count < PHASE_CHARS) begin
        // hold off mid-phase until the block has nothing left in flight
        if (ph == 4 && !paused && sent_chars - start_count >= PHASE_CHARS / 2) begin
          settle();
          paused = 1'b1;
        end
        codes.delete();
        shape = $urandom_range(99);
        if (shape >= 3 && shape < 83) begin
          // well-formed number with random content
          case ($urandom_range(2))
            1: codes.push_back(CH_PLUS);
            2: codes.push_back(CH_MINUS);
            default: ;
          endcase
          if ($urandom_range(9) == 0) begin
            // at or just past the signed magnitude limit
            for (int c = 0; c < near_limit.len(); c++)
              codes.push_back(CODE_W'(near_limit[c]));
            codes.push_back(CH_ZERO + CODE_W'($urandom_range(7, 9)));
          end else begin
            n = $urandom_range(1, 10);
            repeat (n) codes.push_back(CH_ZERO + CODE_W'($urandom_range(9)));
          end
          if ($urandom_range(3) != 0) begin
            codes.push_back(CH_POINT);
            n = $urandom_range(0, shadow_frac + 1);
            repeat (n) codes.push_back(CH_ZERO + CODE_W'($urandom_range(9)));
          end
          // now and then a stray character breaks the number
          if ($urandom_range(9) == 0)
            codes.insert($urandom_range(codes.size()), random_noise());
        end else if (shape >= 83) begin
          n = $urandom_range(1, 6);
          repeat (n) codes.push_back(random_noise());
        end
        foreach (codes[c]) send_char(codes[c], 1'b0, no_number);
        send_char(CH_END, 1'b0, no_number);
      end
    end

    settle();
    if (expected_numbers.size() != 0)
      report_mismatch($sformatf("%0d numbers never arrived", expected_numbers.size()));

    $display("covered %0d character beats and %0d numbers over frac_digits 0 to 15,",
             sent_chars, numbers_checked);
    $display("with sender and receiver stalls in both balances and a stall-free stretch");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
